// ----- rtl/stq_pkg.sv -----
// Shared types and codes of the sorted timer queue.
package stq_pkg;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_DEL    = 3'd1;
    localparam logic [2:0] OP_DELOWN = 3'd2;
    localparam logic [2:0] OP_EXISTS = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_WAIT   = 3'd5;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_WAIT  = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] owner;
        logic [31:0] timer_id;
        logic [31:0] interval_ms;
        logic [31:0] param;
    } stq_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic        found;
        logic [15:0] fired_owner;
        logic [31:0] fired_id;
        logic [31:0] fired_param;
        logic [47:0] wait_ms;
        logic        last;
    } stq_out_t;

    typedef enum logic [2:0] {
        CLS_ADD,
        CLS_DEL,
        CLS_DELOWN,
        CLS_EXISTS,
        CLS_TICK,
        CLS_WAIT,
        CLS_NOP
    } stq_cls_t;

    typedef struct packed {
        stq_cls_t cls;
        stq_in_t  item;
    } stq_cmd_t;

    typedef struct packed {
        logic [15:0] owner;
        logic [31:0] timer_id;
        logic [31:0] param;
        logic [31:0] interval;
        logic [47:0] expiry;
    } stq_slot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_FIRE,
        ST_ACK
    } stq_state_t;

endpackage

// ----- rtl/stq_front.sv -----
// Front end: accept input beats, classify the op and queue them for the engine.
module stq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  stq_pkg::stq_in_t  in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output stq_pkg::stq_cmd_t cmd
);
    import stq_pkg::*;

    stq_cmd_t   q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    stq_cmd_t   cls_cmd;
    logic       push, pop;

    always_comb
    begin
        cls_cmd.item = in_data;
        unique case (in_data.op)
            OP_ADD:    cls_cmd.cls = CLS_ADD;
            OP_DEL:    cls_cmd.cls = CLS_DEL;
            OP_DELOWN: cls_cmd.cls = CLS_DELOWN;
            OP_EXISTS: cls_cmd.cls = CLS_EXISTS;
            OP_TICK:   cls_cmd.cls = CLS_TICK;
            OP_WAIT:   cls_cmd.cls = CLS_WAIT;
            default:   cls_cmd.cls = CLS_NOP;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/stq_engine.sv -----
// Back end: sorted slot table, clock and result register.
module stq_engine #(
    parameter int MAX_TIMERS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  stq_pkg::stq_cmd_t          cmd,
    output logic                       out_valid,
    input  logic                       out_ready,
    output stq_pkg::stq_out_t          out_data,
    output logic                       idle,
    output logic [$clog2(MAX_TIMERS+1)-1:0] count
);
    import stq_pkg::*;

    localparam int IW = $clog2(MAX_TIMERS);
    localparam int CW = $clog2(MAX_TIMERS + 1);

    stq_state_t  state_reg, state_next;
    stq_cmd_t    cmd_reg, cmd_next;
    stq_slot_t   slots_reg [MAX_TIMERS];
    stq_slot_t   slots_next [MAX_TIMERS];
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] fired_reg, fired_next;
    logic [47:0] now_reg, now_next;
    logic        hit_reg, hit_next;
    stq_out_t    res_reg, res_next;
    stq_out_t    pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;
    stq_out_t    out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic        out_free;
    logic [31:0] add_itv;
    logic [47:0] add_exp, fire_exp;
    logic        match_any;
    logic [IW-1:0] match_pos, lt_pos, fire_pos;
    logic        fire_cond;
    stq_slot_t   add_slot, fire_slot;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign idle      = (state_reg == ST_IDLE);
    assign count     = count_reg;

    always_comb
    begin
        add_itv   = (cmd_reg.item.interval_ms == 32'd0) ? 32'd1 : cmd_reg.item.interval_ms;
        add_exp   = now_reg + {16'd0, add_itv};
        fire_exp  = now_reg + {16'd0, slots_reg[0].interval};
        add_slot  = '{cmd_reg.item.owner, cmd_reg.item.timer_id, cmd_reg.item.param,
                      add_itv, add_exp};
        fire_slot = slots_reg[0];
        fire_slot.expiry = fire_exp;
        fire_cond = (fired_reg < count_reg) && (slots_reg[0].expiry <= now_reg);
        match_any = 1'b0;
        match_pos = '0;
        lt_pos    = count_reg[IW-1:0];
        fire_pos  = IW'(count_reg - CW'(1));
        for (int j = MAX_TIMERS - 1; j >= 0; j--)
        begin
            if (CW'(j) < count_reg)
            begin
                if (slots_reg[j].owner == cmd_reg.item.owner &&
                    (cmd_reg.cls == CLS_DELOWN || slots_reg[j].timer_id == cmd_reg.item.timer_id))
                begin
                    match_any = 1'b1;
                    match_pos = IW'(j);
                end
                if (add_exp < slots_reg[j].expiry)
                begin
                    lt_pos = IW'(j);
                end
                if (j >= 1 && slots_reg[j].expiry >= fire_exp)
                begin
                    fire_pos = IW'(j - 1);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.cls) inside
                        CLS_ADD, CLS_DEL, CLS_DELOWN, CLS_EXISTS: state_next = ST_SCAN;
                        CLS_TICK:                                 state_next = ST_FIRE;
                        default:                                  state_next = ST_ACK;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (match_any && (cmd_reg.cls == CLS_DEL || cmd_reg.cls == CLS_EXISTS))
                begin
                    state_next = ST_ACK;
                end
                else if (!match_any)
                begin
                    state_next = (cmd_reg.cls == CLS_ADD) ? ST_PLACE : ST_ACK;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_ACK;
            end
            ST_FIRE:
            begin
                if (!fire_cond && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready       = 1'b0;
        cmd_next        = cmd_reg;
        slots_next      = slots_reg;
        count_next      = count_reg;
        fired_next      = fired_reg;
        now_next        = now_reg;
        hit_next        = hit_reg;
        res_next        = res_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next        = cmd;
                    hit_next        = 1'b0;
                    fired_next      = '0;
                    pend_valid_next = 1'b0;
                    res_next        = '0;
                    res_next.kind   = KIND_ACK;
                    res_next.last   = 1'b1;
                    if (cmd.cls == CLS_TICK)
                    begin
                        now_next = now_reg + 48'd1;
                    end
                    if (cmd.cls == CLS_WAIT)
                    begin
                        res_next.kind  = KIND_WAIT;
                        res_next.found = (count_reg != '0);
                        if (count_reg != '0 && slots_reg[0].expiry > now_reg)
                        begin
                            res_next.wait_ms = slots_reg[0].expiry - now_reg;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                res_next.found = hit_reg || match_any;
                if (match_any)
                begin
                    hit_next = 1'b1;
                    if (cmd_reg.cls != CLS_EXISTS)
                    begin
                        for (int j = 0; j < MAX_TIMERS - 1; j++)
                        begin
                            if (IW'(j) >= match_pos)
                            begin
                                slots_next[j] = slots_reg[j + 1];
                            end
                        end
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            ST_PLACE:
            begin
                if (count_reg >= CW'(MAX_TIMERS))
                begin
                    res_next.status = 1'b1;
                end
                else
                begin
                    for (int j = 1; j < MAX_TIMERS; j++)
                    begin
                        if (IW'(j) > lt_pos)
                        begin
                            slots_next[j] = slots_reg[j - 1];
                        end
                    end
                    slots_next[lt_pos] = add_slot;
                    count_next = count_reg + CW'(1);
                end
            end
            ST_FIRE:
            begin
                if (fire_cond)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                        end
                        for (int j = 0; j < MAX_TIMERS - 1; j++)
                        begin
                            if (IW'(j) < fire_pos)
                            begin
                                slots_next[j] = slots_reg[j + 1];
                            end
                        end
                        slots_next[fire_pos] = fire_slot;
                        pend_next             = '0;
                        pend_next.kind        = KIND_FIRED;
                        pend_next.fired_owner = slots_reg[0].owner;
                        pend_next.fired_id    = slots_reg[0].timer_id;
                        pend_next.fired_param = slots_reg[0].param;
                        pend_valid_next       = 1'b1;
                        fired_next            = fired_reg + CW'(1);
                    end
                end
                else if (out_free)
                begin
                    out_next       = pend_valid_reg ? pend_reg : res_reg;
                    out_next.last  = 1'b1;
                    out_valid_next = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        slots_reg <= slots_next;
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            fired_reg      <= '0;
            now_reg        <= '0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            fired_reg      <= fired_next;
            now_reg        <= now_next;
            hit_reg        <= hit_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

// ----- rtl/sorted_timer_queue_top.sv -----
// Top level of the sorted timer queue: front queue and timer engine.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_data  (stq_in_t)
//  out     | output    | out_valid/out_ready| out_data (stq_out_t)
//
// Add scans, dropping one replaced entry per step, then places the new
// entry; delete and exists scan once; delete-by-owner drops one match per
// step; wait and unknown ops skip the scan. A tick fires each due timer in
// turn (at most MAX_TIMERS), one result beat per cycle while out takes
// them. The engine handles one op at a time; a two-beat queue keeps
// accepting meanwhile. Reset clears the count and clock; no clearing pass
// is needed. A stalled out channel holds the engine at its next result.
module sorted_timer_queue_top #(
    parameter int MAX_TIMERS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  stq_pkg::stq_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output stq_pkg::stq_out_t out_data
);
    import stq_pkg::*;

    localparam int CW = $clog2(MAX_TIMERS + 1);

    logic          cmd_valid;
    logic          cmd_ready;
    stq_cmd_t      cmd;
    logic          eng_idle;
    logic [CW-1:0] eng_count;

    stq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    stq_engine #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .idle      (eng_idle),
        .count     (eng_count)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        eng_count <= CW'(MAX_TIMERS))
        else $error("entry count above table size");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        eng_idle |=> $stable(eng_count))
        else $error("entry count changed while engine idle");

    a_fired_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind == KIND_FIRED) |-> (!out_data.status && !out_data.found))
        else $error("fired beat carries status or found");

endmodule
